[rtl/ptt_pkg.sv]
// Shared definitions for the periodic timer table: sizes, request and domain
// codes, register indexes, the table access structs and the range clipping helper.
// No dependencies.
package ptt_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int IDX_W      = $clog2(NUM_TIMERS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int DATA_W     = 32;
  localparam int ID_W       = 4;
  localparam int CFG_W      = 5;
  localparam int ADDR_W     = 3;

  // Request codes.
  localparam logic [1:0] REQ_ADD     = 2'd0;
  localparam logic [1:0] REQ_CLEAR   = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;
  localparam logic [1:0] REQ_TICK    = 2'd3;

  // Tick domains.
  localparam logic [1:0] DOM_FAST = 2'd0;
  localparam logic [1:0] DOM_MS   = 2'd1;
  localparam logic [1:0] DOM_SEC  = 2'd2;

  // Register indexes, taken from bit 2 of the byte address.
  localparam logic REG_FIRST_MS  = 1'b0;
  localparam logic REG_FIRST_SEC = 1'b1;

  localparam logic [CFG_W-1:0] FIRST_MS_RESET  = 5'd4;
  localparam logic [CFG_W-1:0] FIRST_SEC_RESET = 5'd8;

  typedef struct packed {
    logic [IDX_W-1:0]  rd_addr;
    logic              cfg_we;
    logic [IDX_W-1:0]  cfg_addr;
    logic [DATA_W-1:0] period;
    logic              reports;
    logic              el_we;
    logic [IDX_W-1:0]  el_addr;
    logic [DATA_W-1:0] elapsed;
  } ptt_mem_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] period;
    logic              reports;
    logic [DATA_W-1:0] elapsed;
  } ptt_mem_rsp_t;

  // Clamps a domain bound into 1 .. NUM_TIMERS.
  function automatic logic [CNT_W-1:0] clip_bound(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return CNT_W'(1);
    end else if (int'(v) > NUM_TIMERS) begin
      return CNT_W'(NUM_TIMERS);
    end else begin
      return CNT_W'(v);
    end
  endfunction

endpackage

[rtl/periodic_timer_table.sv]
// Top level of the periodic timer table: configuration registers on an APB-style
// port, the request sequencer and the timer table memories.
// Depends on ptt_pkg, ptt_ctrl and ptt_table.
//
// A request is taken at a rising edge with start high and busy low. Add, clear
// and restart edit one entry and give exactly one result on the next cycle;
// busy stays low, so such requests can follow one another every cycle. A tick
// walks its domain's id range reading one table entry per cycle from the timer
// memory; busy stays high through the walk, a drain state and a done state
// (just the done state when the range is empty). Each expiring timer with a
// handler gives one result with fired set, in ascending id order; the final
// result of a tick arrives in the last busy cycle's successor and carries
// last, and a tick with no report gives a single result with fired clear.
// Every result is shown for exactly one cycle on strobe and must be taken then,
// because nothing here can hold it back. system_time counts millisecond ticks
// and already includes the tick that produced a result. After reset the table
// reads as empty at once; there is no clearing pass. Registers must be written
// only while the block is idle; the block itself does not enforce this.
module periodic_timer_table (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ptt_pkg::ADDR_W-1:0]      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      req_type,
  input  logic [ptt_pkg::ID_W-1:0]        task_id,
  input  logic [ptt_pkg::DATA_W-1:0]      timeout,
  input  logic                            has_handler,
  input  logic [1:0]                      tick_domain,
  output logic                            strobe,
  output logic                            ok,
  output logic                            fired,
  output logic [ptt_pkg::ID_W-1:0]        fired_task,
  output logic                            last,
  output logic [ptt_pkg::DATA_W-1:0]      system_time
);
  import ptt_pkg::*;

  logic [CFG_W-1:0] first_ms_task;
  logic [CFG_W-1:0] first_sec_task;
  logic             cfg_wr;
  ptt_mem_req_t     mem_req;
  ptt_mem_rsp_t     mem_rsp;

  // The port never waits, so a write lands in the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Registers sit on word addresses; bit 2 selects between the two of them.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_ms_task  <= FIRST_MS_RESET;
      first_sec_task <= FIRST_SEC_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_FIRST_MS:  first_ms_task  <= pwdata[CFG_W-1:0];
        REG_FIRST_SEC: first_sec_task <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FIRST_MS:  prdata = 32'(first_ms_task);
      REG_FIRST_SEC: prdata = 32'(first_sec_task);
      default:       prdata = '0;
    endcase
  end

  // The sequencer owns every table write; the table answers one read per cycle.
  ptt_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .task_id        (task_id),
    .timeout        (timeout),
    .has_handler    (has_handler),
    .tick_domain    (tick_domain),
    .first_ms_task  (first_ms_task),
    .first_sec_task (first_sec_task),
    .mem_req        (mem_req),
    .mem_rsp        (mem_rsp),
    .strobe         (strobe),
    .ok             (ok),
    .fired          (fired),
    .fired_task     (fired_task),
    .last           (last),
    .ms_ticks       (system_time)
  );

  ptt_table u_table (
    .clk (clk),
    .rst (rst),
    .req (mem_req),
    .rsp (mem_rsp)
  );

endmodule

[rtl/ptt_table.sv]
// Timer table storage: a period/handler memory and an elapsed-count memory,
// each with one write port and a registered read. Depends on ptt_pkg.
module ptt_table (
  input  logic                  clk,
  input  logic                  rst,
  input  ptt_pkg::ptt_mem_req_t req,
  output ptt_pkg::ptt_mem_rsp_t rsp
);
  import ptt_pkg::*;

  logic [DATA_W:0]   cfg_mem [NUM_TIMERS];
  logic [DATA_W-1:0] el_mem  [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] cfg_vld;
  logic [NUM_TIMERS-1:0] el_vld;
  logic [DATA_W:0]   cfg_q;
  logic [DATA_W-1:0] el_q;
  logic              cfg_hit;
  logic              el_hit;

  always_ff @(posedge clk) begin
    if (req.cfg_we) begin
      cfg_mem[req.cfg_addr] <= {req.reports, req.period};
    end
    if (req.el_we) begin
      el_mem[req.el_addr] <= req.elapsed;
    end
    cfg_q   <= cfg_mem[req.rd_addr];
    el_q    <= el_mem[req.rd_addr];
    cfg_hit <= cfg_vld[req.rd_addr];
    el_hit  <= el_vld[req.rd_addr];
  end

  // Entries never written read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_vld <= '0;
      el_vld  <= '0;
    end else begin
      if (req.cfg_we) begin
        cfg_vld[req.cfg_addr] <= 1'b1;
      end
      if (req.el_we) begin
        el_vld[req.el_addr] <= 1'b1;
      end
    end
  end

  assign rsp.period  = cfg_hit ? cfg_q[DATA_W-1:0] : '0;
  assign rsp.reports = cfg_hit ? cfg_q[DATA_W] : 1'b0;
  assign rsp.elapsed = el_hit ? el_q : '0;

endmodule

[rtl/ptt_ctrl.sv]
// Request sequencer: applies edits to the table, walks a tick domain with one
// table read per cycle and writes counts back, and forms the result stream.
// Depends on ptt_pkg.
module ptt_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    req_type,
  input  logic [ptt_pkg::ID_W-1:0]      task_id,
  input  logic [ptt_pkg::DATA_W-1:0]    timeout,
  input  logic                          has_handler,
  input  logic [1:0]                    tick_domain,
  input  logic [ptt_pkg::CFG_W-1:0]     first_ms_task,
  input  logic [ptt_pkg::CFG_W-1:0]     first_sec_task,
  output ptt_pkg::ptt_mem_req_t         mem_req,
  input  ptt_pkg::ptt_mem_rsp_t         mem_rsp,
  output logic                          strobe,
  output logic                          ok,
  output logic                          fired,
  output logic [ptt_pkg::ID_W-1:0]      fired_task,
  output logic                          last,
  output logic [ptt_pkg::DATA_W-1:0]    ms_ticks
);
  import ptt_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]        state;
  logic [IDX_W-1:0]  addr;
  logic [IDX_W-1:0]  last_addr;
  logic              rd_vld;
  logic [IDX_W-1:0]  rd_idx;
  logic              pend_vld;
  logic [IDX_W-1:0]  pend_id;

  logic              accept;
  logic              id_ok;
  logic              edit_ok;
  logic [CNT_W-1:0]  lo;
  logic [CNT_W-1:0]  hi;
  logic [CNT_W-1:0]  hi_m1;
  logic              active;
  logic [DATA_W-1:0] inc;
  logic              fire;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign id_ok  = (task_id != '0) && (int'(task_id) < NUM_TIMERS);

  always_comb begin
    case (tick_domain)
      DOM_FAST: begin
        lo = CNT_W'(1);
        hi = clip_bound(first_ms_task);
      end
      DOM_MS: begin
        lo = clip_bound(first_ms_task);
        hi = clip_bound(first_sec_task);
      end
      DOM_SEC: begin
        lo = clip_bound(first_sec_task);
        hi = CNT_W'(NUM_TIMERS);
      end
      default: begin
        lo = CNT_W'(1);
        hi = CNT_W'(1);
      end
    endcase
    hi_m1 = hi - CNT_W'(1);
  end

  // Count update for the entry whose read data is present this cycle.
  assign active = (mem_rsp.period != '0);
  assign inc    = mem_rsp.elapsed + DATA_W'(1);
  assign fire   = active && (inc >= mem_rsp.period);

  always_comb begin
    mem_req          = '0;
    mem_req.rd_addr  = addr;
    mem_req.cfg_addr = IDX_W'(task_id);
    mem_req.el_addr  = IDX_W'(task_id);
    edit_ok          = 1'b0;
    if (accept) begin
      case (req_type)
        REQ_ADD: begin
          edit_ok = id_ok && (timeout != '0);
          mem_req.cfg_we  = edit_ok;
          mem_req.el_we   = edit_ok;
          mem_req.period  = timeout;
          mem_req.reports = has_handler;
        end
        REQ_CLEAR: begin
          edit_ok = id_ok;
          mem_req.cfg_we = id_ok;
          mem_req.el_we  = id_ok;
        end
        REQ_RESTART: begin
          edit_ok = id_ok;
          mem_req.el_we = id_ok;
        end
        default: begin
          edit_ok = 1'b1;
        end
      endcase
    end
    if (rd_vld && active) begin
      mem_req.el_we   = 1'b1;
      mem_req.el_addr = rd_idx;
      mem_req.elapsed = fire ? '0 : inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_vld   <= 1'b0;
      pend_vld <= 1'b0;
      strobe   <= 1'b0;
      ms_ticks <= '0;
    end else begin
      strobe <= 1'b0;
      rd_vld <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req_type == REQ_TICK) begin
              if (tick_domain == DOM_MS) begin
                ms_ticks <= ms_ticks + DATA_W'(1);
              end
              if (lo < hi) begin
                state     <= ST_WALK;
                addr      <= lo[IDX_W-1:0];
                last_addr <= hi_m1[IDX_W-1:0];
              end else begin
                state <= ST_DONE;
              end
            end else begin
              strobe     <= 1'b1;
              ok         <= edit_ok;
              fired      <= 1'b0;
              fired_task <= '0;
              last       <= 1'b1;
            end
          end
        end
        ST_WALK: begin
          rd_vld <= 1'b1;
          rd_idx <= addr;
          if (addr == last_addr) begin
            state <= ST_DRAIN;
          end else begin
            addr <= addr + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          strobe     <= 1'b1;
          ok         <= 1'b1;
          fired      <= pend_vld;
          fired_task <= pend_vld ? ID_W'(pend_id) : '0;
          last       <= 1'b1;
          pend_vld   <= 1'b0;
          state      <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // A firing entry is held until the next, so the final one can carry last.
      if (rd_vld && fire && mem_rsp.reports) begin
        if (pend_vld) begin
          strobe     <= 1'b1;
          ok         <= 1'b1;
          fired      <= 1'b1;
          fired_task <= ID_W'(pend_id);
          last       <= 1'b0;
        end
        pend_vld <= 1'b1;
        pend_id  <= rd_idx;
      end
    end
  end

endmodule

[rtl/ptt_check.sv]
// Port-level checks on the periodic timer table's request and result streams,
// and the bind that attaches them to the top level. Depends on ptt_pkg.
module ptt_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic [1:0]                   req_type,
  input logic                         strobe,
  input logic                         ok,
  input logic                         fired,
  input logic [ptt_pkg::ID_W-1:0]     fired_task,
  input logic                         last,
  input logic [ptt_pkg::DATA_W-1:0]   system_time
);
  import ptt_pkg::*;

  // An edit request is answered on the very next cycle with a single result.
  a_edit_answer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type != REQ_TICK) |=> (strobe && last && !fired))
    else $error("edit request not answered by a single result");

  // A reported expiry always comes with ok and a nonzero id.
  a_fire_id: assert property (@(posedge clk) disable iff (rst)
    (strobe && fired) |-> (ok && fired_task != '0))
    else $error("fire result without ok or id");

  // Going idle coincides with the closing result of a tick.
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (strobe && last))
    else $error("busy dropped without a final result");

  // Results before the final one only appear while a tick is in progress.
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> busy)
    else $error("non-final result while idle");

  // System time only ever steps by one.
  a_time_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(system_time)) |->
      (system_time == $past(system_time) + DATA_W'(1)))
    else $error("system time jumped");

endmodule

bind periodic_timer_table ptt_check u_check (.*);
